// File: rtl/websocket_frame_deframer_unmask_unit_macros.svh
// Assertion macros shared by the checker files of the WebSocket deframer.
// No dependencies; include once per file that asserts.
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNMASK_UNIT_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNMASK_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WSDF_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wsdf assertion failed");

// Next-cycle implication, disabled during reset.
`define WSDF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wsdf assertion failed");

`endif

// File: rtl/wsdf_pkg.sv
// Shared types and codes of the WebSocket deframer/unmasker.
// No dependencies.
`default_nettype none

package wsdf_pkg;

  // result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_ERR   = 2'd2;

  // RFC 6455 opcodes accepted by the parser
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  // length codes of header byte 1
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // one result item
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [3:0] frame_opcode;
    logic       frame_end;
  } result_t;

  function automatic logic opcode_ok(input logic [3:0] op);
    return (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BIN) ||
           (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
  endfunction

endpackage

`default_nettype wire

// File: rtl/wsdf_in_stage.sv
// Input register of the deframer: holds one received byte until the parser takes it.
// No package dependencies.
`default_nettype none

module wsdf_in_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_byte,
  input  wire logic       advance,
  output logic            in_valid,
  output logic [7:0]      in_byte
);

  // free when empty or when the held byte moves on this cycle
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_byte;
    end
  end

endmodule

`default_nettype wire

// File: rtl/wsdf_parser.sv
// Header parser, unmasker and result register of the WebSocket deframer.
// Uses wsdf_pkg for result_t, kind codes, opcodes and length codes.
`default_nettype none

module wsdf_parser (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_byte,
  output logic            advance,
  input  wire logic       out_ready,
  output logic            out_valid,
  output wsdf_pkg::result_t result
);

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_EXTHI = 3'd2,
    PH_EXTLO = 3'd3,
    PH_MASK  = 3'd4,
    PH_DATA  = 3'd5
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  cur_opcode, cur_opcode_next;
  logic        is_masked, is_masked_next;
  logic [7:0]  ext_len_hi, ext_len_hi_next;
  logic [15:0] remaining, remaining_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  byte_pos, byte_pos_next;

  logic              emit;
  wsdf_pkg::result_t res_next;

  logic [6:0]  len_code;
  logic [15:0] len_val;
  logic [15:0] rem_dec;
  logic [7:0]  key_byte;

  // byte moves on when the result slot is free or is drained this cycle
  assign advance = in_valid && (!out_valid || out_ready);

  assign len_code = in_byte[6:0];
  assign rem_dec  = remaining - 16'd1;

  // mask key byte for the current payload position, first key byte on top
  always_comb begin
    unique case (byte_pos)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  // next state and result for the byte at the parser input
  always_comb begin
    phase_next      = phase;
    cur_opcode_next = cur_opcode;
    is_masked_next  = is_masked;
    ext_len_hi_next = ext_len_hi;
    remaining_next  = remaining;
    mask_key_next   = mask_key;
    byte_pos_next   = byte_pos;
    emit            = 1'b0;
    len_val         = 16'd0;
    res_next        = '{kind: wsdf_pkg::KIND_DATA, out_byte: 8'd0,
                        frame_opcode: cur_opcode, frame_end: 1'b1};

    unique case (phase)
      PH_HDR1: begin
        is_masked_next = in_byte[7];
        if (len_code == wsdf_pkg::LEN_EXT64) begin
          phase_next    = PH_HDR0;
          emit          = 1'b1;
          res_next.kind = wsdf_pkg::KIND_ERR;
        end else if (len_code == wsdf_pkg::LEN_EXT16) begin
          phase_next = PH_EXTHI;
        end else begin
          len_val        = {9'd0, len_code};
          remaining_next = len_val;
          byte_pos_next  = 2'd0;
          if (in_byte[7]) begin
            phase_next = PH_MASK;
          end else if (len_val == 16'd0) begin
            phase_next    = PH_HDR0;
            emit          = 1'b1;
            res_next.kind = wsdf_pkg::KIND_EMPTY;
          end else begin
            phase_next = PH_DATA;
          end
        end
      end

      PH_EXTHI: begin
        ext_len_hi_next = in_byte;
        phase_next      = PH_EXTLO;
      end

      PH_EXTLO: begin
        len_val        = {ext_len_hi, in_byte};
        remaining_next = len_val;
        byte_pos_next  = 2'd0;
        if (is_masked) begin
          phase_next = PH_MASK;
        end else if (len_val == 16'd0) begin
          phase_next    = PH_HDR0;
          emit          = 1'b1;
          res_next.kind = wsdf_pkg::KIND_EMPTY;
        end else begin
          phase_next = PH_DATA;
        end
      end

      PH_MASK: begin
        mask_key_next = {mask_key[23:0], in_byte};
        if (byte_pos == 2'd3) begin
          byte_pos_next = 2'd0;
          if (remaining == 16'd0) begin
            phase_next    = PH_HDR0;
            emit          = 1'b1;
            res_next.kind = wsdf_pkg::KIND_EMPTY;
          end else begin
            phase_next = PH_DATA;
          end
        end else begin
          byte_pos_next = byte_pos + 2'd1;
        end
      end

      PH_DATA: begin
        emit               = 1'b1;
        res_next.out_byte  = is_masked ? (in_byte ^ key_byte) : in_byte;
        remaining_next     = rem_dec;
        res_next.frame_end = (rem_dec == 16'd0);
        if (rem_dec == 16'd0) begin
          phase_next    = PH_HDR0;
          byte_pos_next = 2'd0;
        end else begin
          byte_pos_next = byte_pos + 2'd1;
        end
      end

      // header byte 0; unreachable codes behave the same
      default: begin
        if (wsdf_pkg::opcode_ok(in_byte[3:0])) begin
          cur_opcode_next = in_byte[3:0];
          phase_next      = PH_HDR1;
        end else begin
          phase_next            = PH_HDR0;
          emit                  = 1'b1;
          res_next.kind         = wsdf_pkg::KIND_ERR;
          res_next.frame_opcode = in_byte[3:0];
        end
      end
    endcase
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HDR0;
      cur_opcode <= 4'd0;
      is_masked  <= 1'b0;
      ext_len_hi <= 8'd0;
      remaining  <= 16'd0;
      mask_key   <= 32'd0;
      byte_pos   <= 2'd0;
    end else if (advance) begin
      phase      <= phase_next;
      cur_opcode <= cur_opcode_next;
      is_masked  <= is_masked_next;
      ext_len_hi <= ext_len_hi_next;
      remaining  <= remaining_next;
      mask_key   <= mask_key_next;
      byte_pos   <= byte_pos_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      result <= res_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/websocket_frame_deframer_unmask_unit.sv
// Channel   | tdata bits                          | tuser     | tlast
// s_axis    | [7:0] in_byte                       | -         | -
// m_axis    | [7:0] out_byte, [11:8] frame_opcode | [1:0] kind| frame_end
//
// Takes one byte per cycle while m_tready low holds no result; a result passes
// through the input register, then parser logic, into the result register.
// Header bytes and mask key bytes give no result, except an error or an empty-frame end.
// rst is synchronous and clears both stage valids and the parser state.
// m_tready low holds the result; s_tready drops only when both stages are full
// and m_tready is low.
// Top level of the WebSocket deframer; uses wsdf_pkg, wsdf_in_stage, wsdf_parser.
`default_nettype none

module websocket_frame_deframer_unmask_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] out_byte, [11:8] frame_opcode, rest zero
  output logic [1:0]       m_tuser,   // [1:0] kind
  output logic             m_tlast    // frame_end
);

  logic              advance;
  logic              in_valid;
  logic [7:0]        in_byte;
  wsdf_pkg::result_t result;

  wsdf_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_byte   (s_tdata),
    .advance  (advance),
    .in_valid (in_valid),
    .in_byte  (in_byte)
  );

  wsdf_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_byte   (in_byte),
    .advance   (advance),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .result    (result)
  );

  // pack result fields onto the master side
  assign m_tdata = {4'd0, result.frame_opcode, result.out_byte};
  assign m_tuser = result.kind;
  assign m_tlast = result.frame_end;

endmodule

`default_nettype wire

// File: rtl/wsdf_checker.sv
// Port-level checks of the WebSocket deframer, bound to the top level.
// Uses wsdf_pkg and the assertion macros header.
`default_nettype none
`include "websocket_frame_deframer_unmask_unit_macros.svh"

module wsdf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic [1:0]  m_tuser,
  input wire logic        m_tlast
);

  logic        kind_ctl;
  logic        op_ok;
  logic        out_stall;
  logic [18:0] m_word;

  assign kind_ctl  = (m_tuser != wsdf_pkg::KIND_DATA);
  assign op_ok     = wsdf_pkg::opcode_ok(m_tdata[11:8]);
  assign out_stall = m_tvalid && !m_tready;
  assign m_word    = {m_tdata, m_tuser, m_tlast};

  // a stalled transaction keeps its payload
  `WSDF_ASSERT_NEXT(a_out_hold, clk, rst, out_stall, m_tvalid && $stable(m_word))

  // input side only backs off while a result is held
  `WSDF_ASSERT_IMPL(a_in_stall, clk, rst, !s_tready, out_stall)

  // empty-end and error results close the frame and carry no byte
  `WSDF_ASSERT_IMPL(a_ctl_closes, clk, rst, m_tvalid && kind_ctl, m_tlast && (m_tdata[7:0] == 8'd0))

  // payload and empty-end results only belong to frames with an accepted opcode
  `WSDF_ASSERT_IMPL(a_op_valid, clk, rst, m_tvalid && (m_tuser != wsdf_pkg::KIND_ERR), op_ok)

  // padding bits of tdata stay zero
  `WSDF_ASSERT_IMPL(a_pad_zero, clk, rst, m_tvalid, m_tdata[15:12] == 4'd0)

endmodule

bind websocket_frame_deframer_unmask_unit wsdf_checker u_wsdf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire
